/* design/sliding_window_quota_limiter_defines.svh */
// assertion macros for the sliding window quota limiter
`ifndef SLIDING_WINDOW_QUOTA_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_QUOTA_LIMITER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SWQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SWQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/swq_pkg.sv */
// shared types and constants of the sliding window quota limiter
`default_nettype none

package swq_pkg;

    localparam int MAX_EVENTS_DEF = 64;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_QUOTA  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 8'd1;

    localparam logic KIND_CHECK = 1'b0;
    localparam logic KIND_ADD   = 1'b1;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] amount;
    } event_t;

    localparam int EVENT_W = $bits(event_t);

    typedef struct packed {
        logic [31:0] quota;
        logic [15:0] window;
    } cfg_t;

endpackage

`default_nettype wire

/* design/swq_ring_mem.sv */
// event ring storage, one write port and one registered read port
`default_nettype none

module swq_ring_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/swq_ctrl.sv */
// ring control: append, expiry walk, quota compare and result register
`default_nettype none

module swq_ctrl import swq_pkg::*; #(
    parameter int MAX_EVENTS = MAX_EVENTS_DEF,
    localparam int IDX_W = $clog2(MAX_EVENTS),
    localparam int CNT_W = $clog2(MAX_EVENTS + 1),
    localparam int SUM_W = 32 + $clog2(MAX_EVENTS)
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_t         cfg,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic         kind,
    input  wire logic [31:0]  amount,
    input  wire logic [31:0]  now,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              allowed,
    output logic              overflow,
    output logic              mem_wr_en,
    output logic [IDX_W-1:0]  mem_wr_addr,
    output event_t            mem_wr_data,
    output logic [IDX_W-1:0]  mem_rd_addr,
    input  wire event_t       mem_rd_data,
    output logic [CNT_W-1:0]  cnt
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [31:0]       amt_reg, amt_next;
    logic [31:0]       now_reg, now_next;
    logic              res_allowed_reg, res_allowed_next;
    logic              res_overflow_reg, res_overflow_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_allowed_reg, out_allowed_next;
    logic              out_overflow_reg, out_overflow_next;

    logic              accept;
    logic              expired;
    logic [31:0]       age;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  tail_inc;
    logic [SUM_W:0]    wide_sum;
    logic              fits;
    logic              full;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(MAX_EVENTS));

    assign age      = now_reg - mem_rd_data.stamp;
    assign expired  = (now_reg >= mem_rd_data.stamp) && (age >= {16'b0, cfg.window});
    assign head_inc = (head_reg == IDX_W'(MAX_EVENTS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(MAX_EVENTS - 1)) ? '0 : tail_reg + 1'b1;
    assign wide_sum = {1'b0, sum_reg} + (SUM_W + 1)'(amt_reg);
    assign fits     = (wide_sum <= (SUM_W + 1)'(cfg.quota));

    // the read port follows the head every cycle, so an expiry step sees its entry next cycle
    assign mem_rd_addr = head_next;
    assign mem_wr_addr = tail_reg;
    assign mem_wr_data = '{stamp: now, amount: amount};

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        amt_next          = amt_reg;
        now_next          = now_reg;
        res_allowed_next  = res_allowed_reg;
        res_overflow_next = res_overflow_reg;
        out_valid_next    = out_valid_reg;
        out_allowed_next  = out_allowed_reg;
        out_overflow_next = out_overflow_reg;
        mem_wr_en         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    amt_next = amount;
                    now_next = now;
                    res_overflow_next = 1'b0;
                    if (kind == KIND_ADD)
                    begin
                        if (full)
                        begin
                            res_allowed_next  = 1'b0;
                            res_overflow_next = 1'b1;
                        end
                        else
                        begin
                            mem_wr_en        = 1'b1;
                            tail_next        = tail_inc;
                            count_next       = count_reg + 1'b1;
                            sum_next         = sum_reg + SUM_W'(amount);
                            res_allowed_next = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        res_allowed_next = 1'b1;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                if (expired)
                begin
                    sum_next   = sum_reg - SUM_W'(mem_rd_data.amount);
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    // last event gone: the window sum is zero
                    if (count_reg == CNT_W'(1))
                    begin
                        res_allowed_next = (amt_reg <= cfg.quota);
                        state_next       = S_DONE;
                    end
                end
                else
                begin
                    res_allowed_next = fits;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    out_allowed_next  = res_allowed_reg;
                    out_overflow_next = res_overflow_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg          <= amt_next;
        now_reg          <= now_next;
        res_allowed_reg  <= res_allowed_next;
        res_overflow_reg <= res_overflow_next;
        out_allowed_reg  <= out_allowed_next;
        out_overflow_reg <= out_overflow_next;
    end

    assign out_valid = out_valid_reg;
    assign allowed   = out_allowed_reg;
    assign overflow  = out_overflow_reg;
    assign cnt       = count_reg;

endmodule

`default_nettype wire

/* design/sliding_window_quota_limiter.sv */
// Sliding window quota limiter. Each input beat is a check (kind 0) or an add (kind 1) of an
// amount at time now, and gives one result beat. Adds go into a ring of MAX_EVENTS entries
// held in one memory; a full ring drops the add with overflow set. A check first expires,
// one entry per cycle through the ring memory read port, every event whose age reaches
// window_seconds, then allows the request when the running window sum plus amount stays
// within the quota; a check on an empty ring is always allowed. One item is worked on at
// a time: an add or a check on an empty ring goes straight to the result register; a check
// that expires events walks them first, then compares unless every stored event expired.
// A result beat waiting on out_ready does not block the next input beat. Configuration is
// written through cfg_wr_en, cfg_index and cfg_data: index 0 the quota, index 1
// window_seconds, other indexes ignored. The ring needs no clearing pass after reset.
`default_nettype none

`include "sliding_window_quota_limiter_defines.svh"

module sliding_window_quota_limiter import swq_pkg::*; #(
    parameter int MAX_EVENTS = MAX_EVENTS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  kind,
    input  wire logic [31:0]           amount,
    input  wire logic [31:0]           now,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       allowed,
    output logic                       overflow
);

    localparam int IDX_W = $clog2(MAX_EVENTS);
    localparam int CNT_W = $clog2(MAX_EVENTS + 1);

    logic [31:0]      quota_reg;
    logic [15:0]      window_reg;
    cfg_t             cfg;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    event_t           mem_wr_data;
    logic [IDX_W-1:0] mem_rd_addr;
    event_t           mem_rd_data;
    logic [CNT_W-1:0] cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quota_reg  <= '0;
            window_reg <= 16'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_QUOTA:  quota_reg  <= cfg_data;
                REG_WINDOW: window_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    assign cfg = '{quota: quota_reg, window: window_reg};

    swq_ring_mem #(
        .DEPTH (MAX_EVENTS),
        .WIDTH (EVENT_W)
    ) u_ring_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    swq_ctrl #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .amount      (amount),
        .now         (now),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .allowed     (allowed),
        .overflow    (overflow),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .cnt         (cnt)
    );

    `SWQ_ASSERT_IMP(a_count_bound, 1'b1, cnt <= CNT_W'(MAX_EVENTS), "event count above ring depth")
    `SWQ_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "beat taken while busy")
    `SWQ_ASSERT_IMP(a_overflow_denied, out_valid && overflow, !allowed, "dropped add reported stored")
    `SWQ_ASSERT_NXT(a_full_no_growth, in_valid && in_ready && cnt == CNT_W'(MAX_EVENTS),
        cnt == CNT_W'(MAX_EVENTS), "full ring changed size on a beat")

endmodule

`default_nettype wire
